[sv/mrgl_pkg.sv]
// ----------------------------------------------------------------------------
// mrgl_pkg
// Shared types and codes for the missing-range gap list.
// ----------------------------------------------------------------------------
`default_nettype none

package mrgl_pkg;

  localparam int unsigned FieldBits = 32;
  localparam int unsigned TotalBits = 5;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_MARK  = 2'd1,
    KIND_RESET = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [FieldBits-1:0] range_start;
    logic [FieldBits-1:0] range_end;
  } in_item_t;

  typedef struct packed {
    logic [FieldBits-1:0] gap_start;
    logic [FieldBits-1:0] gap_end;
    logic                 gap_valid;
    logic                 last_of_run;
    logic [TotalBits-1:0] gap_total;
    logic                 status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_W1,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic rd;
    logic eval;
    logic wr1;
    logic fin;
    logic emit_rd;
    logic emit_ld;
  } cmd_t;

  typedef struct packed {
    logic modify;
    logic more;
    logic w1_pend;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage

`default_nettype wire

[sv/mrgl_in_if.sv]
// ----------------------------------------------------------------------------
// mrgl_in_if
// Operation channel: valid, ready and one operation beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrgl_in_if;
  logic               valid;
  logic               ready;
  mrgl_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/mrgl_out_if.sv]
// ----------------------------------------------------------------------------
// mrgl_out_if
// Result channel: valid, ready and one listed gap per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrgl_out_if;
  logic                valid;
  logic                ready;
  mrgl_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/mrgl_ctrl.sv]
// ----------------------------------------------------------------------------
// mrgl_ctrl
// Sequencer: scans the held list, writes the new list if the operation changes it, then emits the list.
// ----------------------------------------------------------------------------
`default_nettype none

module mrgl_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire mrgl_pkg::stat_t stat_i,
  output mrgl_pkg::cmd_t       cmd_o
);

  mrgl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrgl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mrgl_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mrgl_pkg::ST_SCAN_RD;
      end
      mrgl_pkg::ST_SCAN_RD: begin
        if (!stat_i.modify) state_d = mrgl_pkg::ST_EMIT_RD;
        else if (stat_i.more) state_d = mrgl_pkg::ST_SCAN_EV;
        else state_d = mrgl_pkg::ST_FIN;
      end
      mrgl_pkg::ST_SCAN_EV: begin
        state_d = stat_i.w1_pend ? mrgl_pkg::ST_SCAN_W1 : mrgl_pkg::ST_SCAN_RD;
      end
      mrgl_pkg::ST_SCAN_W1: state_d = mrgl_pkg::ST_SCAN_RD;
      mrgl_pkg::ST_FIN:     state_d = mrgl_pkg::ST_EMIT_RD;
      mrgl_pkg::ST_EMIT_RD: state_d = mrgl_pkg::ST_EMIT_OUT;
      mrgl_pkg::ST_EMIT_OUT: begin
        if (stat_i.out_free) begin
          state_d = stat_i.emit_last ? mrgl_pkg::ST_IDLE : mrgl_pkg::ST_EMIT_RD;
        end
      end
      default: state_d = mrgl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mrgl_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.start   = in_valid_i;
      end
      mrgl_pkg::ST_SCAN_RD:  cmd_o.rd      = stat_i.modify & stat_i.more;
      mrgl_pkg::ST_SCAN_EV:  cmd_o.eval    = 1'b1;
      mrgl_pkg::ST_SCAN_W1:  cmd_o.wr1     = 1'b1;
      mrgl_pkg::ST_FIN:      cmd_o.fin     = 1'b1;
      mrgl_pkg::ST_EMIT_RD:  cmd_o.emit_rd = 1'b1;
      mrgl_pkg::ST_EMIT_OUT: cmd_o.emit_ld = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/mrgl_dp.sv]
// ----------------------------------------------------------------------------
// mrgl_dp
// Datapath: two-bank gap memory, merge/cut unit, counters, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrgl_dp #(
  parameter int unsigned MAX_GAPS    = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mrgl_pkg::cmd_t       cmd_i,
  input  wire mrgl_pkg::in_item_t   op_i,
  output mrgl_pkg::stat_t           stat_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output mrgl_pkg::out_item_t       out_data_o
);

  localparam int unsigned OW = OFFSET_BITS;
  localparam int unsigned IW = $clog2(MAX_GAPS);
  localparam int unsigned CW = $clog2(MAX_GAPS + 1);
  localparam int unsigned AW = IW + 1;

  logic [2*OW-1:0] mem_q [2**AW];
  logic [2*OW-1:0] rdat_q;

  logic          bank_q;
  logic [CW-1:0] held_q, idx_q, n_q, scan_cnt_q;
  logic [OW-1:0] as_q, ae_q, w1s_q, w1e_q;
  logic          is_add_q, placed_q, mod_q, status_q;
  logic          out_valid_q;
  mrgl_pkg::out_item_t out_q;

  logic [OW-1:0] in_s, in_e, gs, ge;
  logic          nonempty, full;

  logic          w0v, w1v, place_now, merge_now;
  logic [OW-1:0] w0s, w0e, w1s, w1e;

  logic          wr_en;
  logic [OW-1:0] wr_s, wr_e;
  logic          fin_wr;
  logic          out_free;

  assign in_s = OW'(op_i.range_start);
  assign in_e = OW'(op_i.range_end);
  assign gs   = rdat_q[2*OW-1:OW];
  assign ge   = rdat_q[OW-1:0];

  assign nonempty = in_e > in_s;
  assign full     = held_q == CW'(MAX_GAPS);

  // per-entry merge or cut
  always_comb begin
    w0v = 1'b0; w0s = gs; w0e = ge;
    w1v = 1'b0; w1s = gs; w1e = ge;
    place_now = 1'b0;
    merge_now = 1'b0;
    if (is_add_q) begin
      if (placed_q) begin
        w0v = 1'b1;
      end else if (ge < as_q) begin
        w0v = 1'b1;
      end else if (gs <= ae_q) begin
        merge_now = 1'b1;
      end else begin
        w0v = 1'b1; w0s = as_q; w0e = ae_q;
        w1v = 1'b1;
        place_now = 1'b1;
      end
    end else begin
      w0v = gs < as_q;
      w0e = (ge < as_q) ? ge : as_q;
      w1v = ge > ae_q;
      w1s = (gs > ae_q) ? gs : ae_q;
    end
  end

  assign fin_wr = cmd_i.fin & is_add_q & ~placed_q;

  always_comb begin
    wr_en = 1'b0; wr_s = w0s; wr_e = w0e;
    if (cmd_i.eval && w0v) begin
      wr_en = 1'b1;
    end else if (cmd_i.wr1) begin
      wr_en = 1'b1; wr_s = w1s_q; wr_e = w1e_q;
    end else if (fin_wr) begin
      wr_en = 1'b1; wr_s = as_q; wr_e = ae_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[{~bank_q, n_q[IW-1:0]}] <= {wr_s, wr_e};
    if (cmd_i.rd || cmd_i.emit_rd) rdat_q <= mem_q[{bank_q, idx_q[IW-1:0]}];
  end

  assign out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= 1'b0;
      held_q      <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      scan_cnt_q  <= '0;
      is_add_q    <= 1'b0;
      placed_q    <= 1'b0;
      mod_q       <= 1'b0;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        idx_q    <= '0;
        n_q      <= '0;
        placed_q <= 1'b0;
        case (op_i.kind)
          mrgl_pkg::KIND_RESET: begin
            is_add_q   <= 1'b1;
            scan_cnt_q <= '0;
            mod_q      <= in_e != '0;
            status_q   <= 1'b0;
            if (in_e == '0) held_q <= '0;
          end
          mrgl_pkg::KIND_ADD, mrgl_pkg::KIND_MARK: begin
            is_add_q   <= op_i.kind == mrgl_pkg::KIND_ADD;
            scan_cnt_q <= held_q;
            mod_q      <= nonempty & ~full;
            status_q   <= nonempty & full;
          end
          default: begin
            mod_q    <= 1'b0;
            status_q <= 1'b0;
          end
        endcase
      end
      if (cmd_i.eval) begin
        idx_q <= idx_q + CW'(1);
        if (w0v) n_q <= n_q + CW'(1);
        if (place_now) placed_q <= 1'b1;
      end
      if (cmd_i.wr1) n_q <= n_q + CW'(1);
      if (cmd_i.fin) begin
        bank_q <= ~bank_q;
        held_q <= n_q + CW'(fin_wr);
        idx_q  <= '0;
      end
      if (cmd_i.emit_ld) idx_q <= idx_q + CW'(1);
      if (cmd_i.emit_ld) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      as_q <= (op_i.kind == mrgl_pkg::KIND_RESET) ? '0 : in_s;
      ae_q <= in_e;
    end else if (cmd_i.eval && merge_now) begin
      as_q <= (gs < as_q) ? gs : as_q;
      ae_q <= (ge > ae_q) ? ge : ae_q;
    end
    if (cmd_i.eval) begin
      w1s_q <= w1s;
      w1e_q <= w1e;
    end
    if (cmd_i.emit_ld) begin
      out_q.gap_valid   <= held_q != '0;
      out_q.gap_start   <= (held_q != '0) ? mrgl_pkg::FieldBits'(gs) : '0;
      out_q.gap_end     <= (held_q != '0) ? mrgl_pkg::FieldBits'(ge) : '0;
      out_q.last_of_run <= stat_o.emit_last;
      out_q.gap_total   <= mrgl_pkg::TotalBits'(held_q);
      out_q.status      <= status_q;
    end
  end

  assign stat_o.modify    = mod_q;
  assign stat_o.more      = idx_q < scan_cnt_q;
  assign stat_o.w1_pend   = w1v;
  assign stat_o.out_free  = out_free;
  assign stat_o.emit_last = (held_q == '0) || (idx_q + CW'(1) == held_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[sv/missing_range_gap_list.sv]
// ----------------------------------------------------------------------------
// missing_range_gap_list
// Sorted list of missing byte ranges with add, mark-received and reset.
// ----------------------------------------------------------------------------
// Each operation beat is taken when the block is idle; the list is then
// rewritten, when the operation changes it, into the spare bank of a
// two-bank memory, one held gap at a time (read, merge or cut, optional
// second write for a split), and the list is emitted one gap per beat.
// An empty list is emitted as one beat with gap_valid low.
`default_nettype none

module missing_range_gap_list #(
  parameter int unsigned MAX_GAPS    = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mrgl_in_if.sink     in_i,
  mrgl_out_if.source  out_o
);

  mrgl_pkg::cmd_t  cmd;
  mrgl_pkg::stat_t stat;
  mrgl_pkg::stat_t stat_fix;

  // the second write is only pending in the cycle it is evaluated
  assign stat_fix.modify    = stat.modify;
  assign stat_fix.more      = stat.more;
  assign stat_fix.w1_pend   = stat.w1_pend & cmd.eval;
  assign stat_fix.out_free  = stat.out_free;
  assign stat_fix.emit_last = stat.emit_last;

  mrgl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat_fix),
    .cmd_o      (cmd)
  );

  mrgl_dp #(
    .MAX_GAPS    (MAX_GAPS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (in_i.data),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("operation taken while busy");

  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.gap_valid |->
      out_o.data.last_of_run && out_o.data.gap_total == '0)
    else $error("empty-list beat malformed");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.status |->
      out_o.data.gap_total == mrgl_pkg::TotalBits'(MAX_GAPS))
    else $error("refusal with list not full");
`endif

endmodule

`default_nettype wire
